// ----- hw/rtl/ise_pkg.sv -----
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types for the insertion sort engine: controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // controller states
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } ise_state_t;

  // controller to datapath
  typedef struct packed {
    logic insert;   // insert the incoming value into the cell row
    logic shift;    // move the row down one cell, dropping cell 0
  } ise_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_entry;  // one entry left in the row
  } ise_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ise_in_if.sv -----
// ----------------------------------------------------------------------------
// ise_in_if
// Input channel: one value to sort and its end-of-set mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_in_if;
  import ise_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ise_out_if.sv -----
// ----------------------------------------------------------------------------
// ise_out_if
// Output channel: sorted values with end-of-run and overflow marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_out_if;
  import ise_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  end_of_run;
  logic  overflow;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/insertion_sort_engine_core.sv -----
// Latency: an item is inserted in the cycle it is accepted; the first sorted
// result is offered the cycle after the item marked last is accepted.
// Throughput: one input item per cycle while filling; a set of N entries then
// drains at one result per cycle while dout is ready; input is held off
// until the final result goes. A single compare-and-shift cell row sets both rates.
// Reset: synchronous, clears fill count, dropped flag and controller state.
// ----------------------------------------------------------------------------
// insertion_sort_engine_core
// Streaming insertion sort of signed 32-bit values with overflow marking.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire       clk,
  input  wire       rst,
  ise_in_if.sink    din,
  ise_out_if.source dout
);
  import ise_pkg::*;

  ise_cmd_t    cmd;
  ise_status_t status;

  // controller
  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_last   (din.is_last),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  ise_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (din.value),
    .sorted_value (dout.sorted_value),
    .end_of_run   (dout.end_of_run),
    .overflow     (dout.overflow),
    .status       (status)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ise_ctrl.sv -----
// ----------------------------------------------------------------------------
// ise_ctrl
// Controller: fills the cell row until the last request of a set, then
// drains it one entry per output request.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire                  in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  ise_pkg::ise_status_t status,
  output ise_pkg::ise_cmd_t    cmd
);
  import ise_pkg::*;

  ise_state_t state;
  ise_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (in_valid && in_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_ready && status.last_entry) state_next = ST_FILL;
      end
      default: state_next = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.insert = 1'b0;
    cmd.shift  = 1'b0;
    case (state)
      ST_FILL: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        cmd.shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ise_datapath.sv -----
// ----------------------------------------------------------------------------
// ise_datapath
// Row of sort cells with parallel compare-and-shift insertion, a fill count
// and a dropped flag. Drains by shifting the row toward cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ise_pkg::ise_cmd_t    cmd,
  input  ise_pkg::data_t       value,
  output ise_pkg::data_t       sorted_value,
  output logic                 end_of_run,
  output logic                 overflow,
  output ise_pkg::ise_status_t status
);
  import ise_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  data_t             slot [CAPACITY];
  logic [CntW-1:0]   count;
  logic              dropped;

  logic [CAPACITY-1:0] greater;  // occupied cell holding a larger value
  logic [CAPACITY-1:0] take;     // cell receives a new value on insert
  data_t               ins_val [CAPACITY];
  logic                room;

  assign room = (count != CntW'(CAPACITY));

  // per-cell compare and insert selection
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign greater[i] = (CntW'(i) < count) && (slot[i] > value);
    assign take[i]    = greater[i] || (CntW'(i) == count);
    if (i == 0) begin : g_first
      assign ins_val[i] = value;
    end else begin : g_rest
      assign ins_val[i] = greater[i-1] ? slot[i-1] : value;
    end
  end

  // cell row: insert, or shift down while draining
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.insert && room && take[i]) begin
          slot[i] <= ins_val[i];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.insert && room && take[i]) begin
          slot[i] <= ins_val[i];
        end else if (cmd.shift) begin
          slot[i] <= slot[i+1];
        end
      end
    end
  end

  // fill count and dropped flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.insert) begin
      if (room) begin
        count <= count + CntW'(1);
      end else begin
        dropped <= 1'b1;
      end
    end else if (cmd.shift) begin
      count <= count - CntW'(1);
      if (status.last_entry) dropped <= 1'b0;
    end
  end

  assign status.last_entry = (count == CntW'(1));
  assign sorted_value      = slot[0];
  assign end_of_run        = status.last_entry;
  assign overflow          = dropped;

endmodule

`default_nettype wire

// ----- dv/insertion_sort_engine_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// insertion_sort_engine_core_tb
// Streams sets of signed values into the sort engine and checks every sorted
// result, its end-of-run mark and its overflow mark against a predicted
// store. Covers extremes, duplicates, full and overflowing stores, random sets
// under random idling on both channels, and a long output hold-off.
// ----------------------------------------------------------------------------

module insertion_sort_engine_core_tb;
  import ise_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          RANDOM_ITEMS = 50;
  localparam int          MAX_REPORTS = 10;
  localparam data_t       VAL_MAX = 32'sh7fffffff;
  localparam data_t       VAL_MIN = 32'sh80000000;

  typedef struct {
    data_t value;
    logic  end_of_run;
    logic  overflow;
  } sorted_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ise_in_if  din_if ();
  ise_out_if dout_if ();

  insertion_sort_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if)
  );

  // predicted store contents and pending sorted results
  data_t          sorted_vals [CAPACITY];
  int             stored_count;
  bit             values_dropped;
  sorted_result_t sorted_results_due [$];

  int  error_count;
  int  items_sent;
  int  results_checked;
  int  sets_sent;
  int  overflow_sets;
  bit  src_idles;
  bit  sink_idles;
  int  hold_cycles_req;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // value mix: full range, extremes and a narrow band for duplicates
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return data_t'(int'($urandom_range(0, 8)) - 4);
      4: return data_t'(int'($urandom_range(0, 1)) - 1);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // insert into the predicted store, queue the run when the set closes
  function automatic void predict_sorted(data_t v, bit last);
    int pos;
    sorted_result_t res;
    if (stored_count >= CAPACITY) begin
      values_dropped = 1'b1;
    end else begin
      pos = stored_count;
      while (pos > 0 && sorted_vals[pos-1] > v) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = v;
      stored_count++;
    end
    if (last) begin
      for (int i = 0; i < stored_count; i++) begin
        res.value      = sorted_vals[i];
        res.end_of_run = (i == stored_count - 1);
        res.overflow   = values_dropped;
        sorted_results_due.push_back(res);
      end
      if (values_dropped) overflow_sets++;
      sets_sent++;
      stored_count   = 0;
      values_dropped = 1'b0;
    end
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_value(data_t v, bit last);
    int gap;
    din_if.valid   <= 1'b1;
    din_if.value   <= v;
    din_if.is_last <= last;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    predict_sorted(v, last);
    items_sent++;
    if (src_idles && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      din_if.valid   <= 1'b0;
      din_if.value   <= data_t'($urandom);
      din_if.is_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(data_t vals [$]);
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_value(pick_value(), i == n - 1);
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    din_if.valid <= 1'b0;
    while (sorted_results_due.size() != 0) @(posedge clk);
  endtask

  // extremes, mixed signs, duplicates, sorted and reversed input
  task automatic test_directed();
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    send_set('{VAL_MAX});
    send_set('{VAL_MIN});
    send_set('{32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN});
    send_set('{32'sd5, 32'sd5, -32'sd5, 32'sd5});
    send_set('{-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    send_set('{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2});
    wait_drained();
  endtask

  // store filled up, last value dropped, then a short set to recover
  task automatic test_store_full();
    src_idles  = 1'b0;
    sink_idles = 1'b1;
    for (int i = 0; i < CAPACITY; i++) send_value(pick_value(), 1'b0);
    send_value(VAL_MIN, 1'b1);
    send_random_set(3);
    wait_drained();
  endtask

  // long output hold-off while the next set keeps coming
  task automatic test_output_backpressure();
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    hold_cycles_req = 250;
    send_random_set(30);
    send_random_set(10);
    wait_drained();
  endtask

  // random sets, mostly small, under changing idle patterns
  task automatic test_random_sets();
    int start;
    int r;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      src_idles  = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 24);
      if (r == 0) n = $urandom_range(CAPACITY - 4, CAPACITY + 6);
      else if (r < 4) n = $urandom_range(13, 40);
      else n = $urandom_range(1, 12);
      send_random_set(n);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // output side: random stalls plus requested hold-offs
  initial begin : sink_driver
    int stall_left;
    stall_left = 0;
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        stall_left = hold_cycles_req;
        hold_cycles_req = 0;
      end else if (stall_left == 0 && sink_idles && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        dout_if.ready <= 1'b0;
        stall_left--;
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    sorted_result_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (sorted_results_due.size() == 0) begin
        note_error($sformatf("unexpected result value=%0d end=%b ovf=%b",
                             dout_if.sorted_value, dout_if.end_of_run, dout_if.overflow));
      end else begin
        want = sorted_results_due.pop_front();
        results_checked++;
        if (dout_if.sorted_value !== want.value || dout_if.end_of_run !== want.end_of_run ||
            dout_if.overflow !== want.overflow) begin
          note_error($sformatf("result %0d: expected value=%0d end=%b ovf=%b, got value=%0d end=%b ovf=%b",
                               results_checked, want.value, want.end_of_run, want.overflow,
                               dout_if.sorted_value, dout_if.end_of_run, dout_if.overflow));
        end
      end
    end
  end

  // no progress on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("TIMEOUT: no request or result accepted for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    sets_sent       = 0;
    overflow_sets   = 0;
    stored_count    = 0;
    values_dropped  = 1'b0;
    src_idles       = 1'b0;
    sink_idles      = 1'b0;
    hold_cycles_req = 0;
    din_if.valid   <= 1'b0;
    din_if.value   <= '0;
    din_if.is_last <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_output_backpressure();
    test_random_sets();

    repeat (10) @(posedge clk);
    $display("Sent %0d values in %0d sets (%0d overflowing), checked %0d sorted results",
             items_sent, sets_sent, overflow_sets, results_checked);
    $display("Mismatches: %0d, results still pending: %0d",
             error_count, sorted_results_due.size());
    if (error_count == 0 && sorted_results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
